[src/srrq_pkg.sv]
package srrq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned RATIO_W = 28;
  localparam int unsigned ADDR_W  = 5;

  localparam logic [RATIO_W-1:0] RATIO_FIELD_MASK = 28'hffffffc;

  typedef enum logic [2:0] {
    REG_CRYSTAL_HZ      = 3'd0,
    REG_LOW_WINDOW_MIN  = 3'd1,
    REG_LOW_WINDOW_MAX  = 3'd2,
    REG_HIGH_WINDOW_MIN = 3'd3,
    REG_HIGH_WINDOW_MAX = 3'd4
  } cfg_reg_t;

  localparam logic [DATA_W-1:0] CRYSTAL_HZ_RESET      = 32'd28800000;
  localparam logic [DATA_W-1:0] LOW_WINDOW_MIN_RESET  = 32'd225001;
  localparam logic [DATA_W-1:0] LOW_WINDOW_MAX_RESET  = 32'd300000;
  localparam logic [DATA_W-1:0] HIGH_WINDOW_MIN_RESET = 32'd900001;
  localparam logic [DATA_W-1:0] HIGH_WINDOW_MAX_RESET = 32'd3200000;

endpackage

[src/sample_rate_ratio_quantizer.sv]
// channel  direction  signals                         item
// s_*      in         s_tvalid s_tready s_tdata[31:0] requested rate
// m_*      out        m_tvalid m_tready m_tdata m_tuser  exact rate, ratio, accepted flag
// apb      in/out     psel penable pwrite paddr pwdata prdata pready  config registers
//
// one item per cycle sustained while m_tready stays high; items pass through the window
// check, two pipelined restoring dividers around the mask stage, and the output register
// synchronous active-high reset clears all valid bits and loads register defaults
// a stall at the output backs up stage by stage; empty stages keep filling
module sample_rate_ratio_quantizer #(
  parameter int unsigned RATIO_SHIFT     = 22,
  parameter int unsigned STEPS_PER_STAGE = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,   // requested_rate
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [63:0]               m_tdata,   // exact_rate[31:0], ratio_word[59:32], zeros
  output logic [0:0]                m_tuser,   // accepted
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [srrq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned NUM_W = srrq_pkg::DATA_W + RATIO_SHIFT;
  localparam int unsigned DW    = srrq_pkg::DATA_W;
  localparam int unsigned RW    = srrq_pkg::RATIO_W;

  logic [DW-1:0] crystal_hz;
  logic [DW-1:0] low_window_min;
  logic [DW-1:0] low_window_max;
  logic [DW-1:0] high_window_min;
  logic [DW-1:0] high_window_max;
  logic [2:0]    reg_idx;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_hz      <= srrq_pkg::CRYSTAL_HZ_RESET;
      low_window_min  <= srrq_pkg::LOW_WINDOW_MIN_RESET;
      low_window_max  <= srrq_pkg::LOW_WINDOW_MAX_RESET;
      high_window_min <= srrq_pkg::HIGH_WINDOW_MIN_RESET;
      high_window_max <= srrq_pkg::HIGH_WINDOW_MAX_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        srrq_pkg::REG_CRYSTAL_HZ:      crystal_hz      <= pwdata;
        srrq_pkg::REG_LOW_WINDOW_MIN:  low_window_min  <= pwdata;
        srrq_pkg::REG_LOW_WINDOW_MAX:  low_window_max  <= pwdata;
        srrq_pkg::REG_HIGH_WINDOW_MIN: high_window_min <= pwdata;
        srrq_pkg::REG_HIGH_WINDOW_MAX: high_window_max <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      srrq_pkg::REG_CRYSTAL_HZ:      prdata = crystal_hz;
      srrq_pkg::REG_LOW_WINDOW_MIN:  prdata = low_window_min;
      srrq_pkg::REG_LOW_WINDOW_MAX:  prdata = low_window_max;
      srrq_pkg::REG_HIGH_WINDOW_MIN: prdata = high_window_min;
      srrq_pkg::REG_HIGH_WINDOW_MAX: prdata = high_window_max;
      default:                       prdata = '0;
    endcase
  end

  logic [NUM_W-1:0] dividend;
  assign dividend = {crystal_hz, {RATIO_SHIFT{1'b0}}};

  // window check stage
  logic          a_valid;
  logic          a_ready;
  logic [DW-1:0] a_req;
  logic          a_rej;
  logic          in_low;
  logic          in_high;
  logic          d1_in_ready;

  assign in_low   = (s_tdata >= low_window_min) && (s_tdata <= low_window_max);
  assign in_high  = (s_tdata >= high_window_min) && (s_tdata <= high_window_max);
  assign a_ready  = !a_valid || d1_in_ready;
  assign s_tready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_tvalid) begin
      a_req <= s_tdata;
      a_rej <= (s_tdata == '0) || !(in_low || in_high);
    end
  end

  // ratio divider
  logic          d1_valid;
  logic          d1_ready;
  logic [DW-1:0] d1_quo;
  logic          d1_rej;

  srrq_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DW),
    .QUO_W  (DW),
    .SIDE_W (1),
    .STEPS  (STEPS_PER_STAGE)
  ) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (d1_in_ready),
    .in_num    (dividend),
    .in_den    (a_req),
    .in_side   (a_rej),
    .out_valid (d1_valid),
    .out_ready (d1_ready),
    .out_quo   (d1_quo),
    .out_side  (d1_rej)
  );

  // ratio mask stage
  logic          c_valid;
  logic          c_ready;
  logic [RW-1:0] c_ratio;
  logic [RW-1:0] ratio_masked;
  logic          c_rej;
  logic          d2_in_ready;

  assign ratio_masked = d1_quo[RW-1:0] & srrq_pkg::RATIO_FIELD_MASK;
  assign c_ready      = !c_valid || d2_in_ready;
  assign d1_ready     = c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && d1_valid) begin
      c_ratio <= ratio_masked;
      c_rej   <= d1_rej || (ratio_masked == '0);
    end
  end

  // exact rate divider
  logic          d2_valid;
  logic          d2_ready;
  logic [DW-1:0] d2_quo;
  logic [RW:0]   d2_side;

  srrq_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DW),
    .QUO_W  (DW),
    .SIDE_W (RW + 1),
    .STEPS  (STEPS_PER_STAGE)
  ) u_exact_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (d2_in_ready),
    .in_num    (dividend),
    .in_den    (DW'(c_ratio)),
    .in_side   ({c_rej, c_ratio}),
    .out_valid (d2_valid),
    .out_ready (d2_ready),
    .out_quo   (d2_quo),
    .out_side  (d2_side)
  );

  // output register
  logic          o_valid;
  logic          o_ready;
  logic          o_accepted;
  logic [DW-1:0] o_exact;
  logic [RW-1:0] o_ratio;
  logic          accept_now;

  assign accept_now = !d2_side[RW] && (d2_quo != '0);
  assign o_ready    = !o_valid || m_tready;
  assign d2_ready   = o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && d2_valid) begin
      o_accepted <= accept_now;
      o_exact    <= accept_now ? d2_quo : '0;
      o_ratio    <= accept_now ? d2_side[RW-1:0] : '0;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {4'b0000, o_ratio, o_exact};
  assign m_tuser  = o_accepted;

endmodule

[src/srrq_div.sv]
module srrq_div #(
  parameter int unsigned NUM_W  = 54,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned QUO_W  = 32,
  parameter int unsigned SIDE_W = 1,
  parameter int unsigned STEPS  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int unsigned STAGES = (NUM_W + STEPS - 1) / STEPS;
  localparam int unsigned PAD_W  = STAGES * STEPS;

  logic              vld  [STAGES];
  logic [DEN_W-1:0]  rem  [STAGES];
  logic [PAD_W-1:0]  num  [STAGES];
  logic [QUO_W-1:0]  quo  [STAGES];
  logic [DEN_W-1:0]  den  [STAGES];
  logic [SIDE_W-1:0] side [STAGES];
  logic              rdy  [STAGES+1];

  assign rdy[STAGES] = out_ready;
  assign in_ready    = rdy[0];
  assign out_valid   = vld[STAGES-1];
  assign out_quo     = quo[STAGES-1];
  assign out_side    = side[STAGES-1];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic              src_valid;
    logic [DEN_W-1:0]  rem_in;
    logic [PAD_W-1:0]  num_in;
    logic [QUO_W-1:0]  quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W-1:0]  rem_next;
    logic [PAD_W-1:0]  num_next;
    logic [QUO_W-1:0]  quo_next;

    if (s == 0) begin : g_head
      assign src_valid = in_valid;
      assign rem_in    = '0;
      assign num_in    = PAD_W'(in_num);
      assign quo_in    = '0;
      assign den_in    = in_den;
      assign side_in   = in_side;
    end else begin : g_body
      assign src_valid = vld[s-1];
      assign rem_in    = rem[s-1];
      assign num_in    = num[s-1];
      assign quo_in    = quo[s-1];
      assign den_in    = den[s-1];
      assign side_in   = side[s-1];
    end

    // restoring division, one quotient bit per step
    always_comb begin : p_steps
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic [DEN_W-1:0] r;
      logic [PAD_W-1:0] n;
      logic [QUO_W-1:0] q;
      r = rem_in;
      n = num_in;
      q = quo_in;
      for (int unsigned k = 0; k < STEPS; k++) begin
        trial = {r, n[PAD_W-1]};
        diff  = trial - {1'b0, den_in};
        n     = {n[PAD_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          r = diff[DEN_W-1:0];
          q = {q[QUO_W-2:0], 1'b1};
        end else begin
          r = trial[DEN_W-1:0];
          q = {q[QUO_W-2:0], 1'b0};
        end
      end
      rem_next = r;
      num_next = n;
      quo_next = q;
    end

    assign rdy[s] = !vld[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && src_valid) begin
        rem[s]  <= rem_next;
        num[s]  <= num_next;
        quo[s]  <= quo_next;
        den[s]  <= den_in;
        side[s] <= side_in;
      end
    end
  end

endmodule

[src/srrq_checker.sv]
module srrq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser
);

  logic [7:0] in_flight;
  logic       s_fire;
  logic       m_fire;

  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 8'(s_fire) - 8'(m_fire);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_fire |-> in_flight != '0)
    else $error("output item without a matching input item");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("rejected item carries nonzero data");

  a_accept_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[33:32] == 2'b00 && m_tdata[59:32] != '0 && m_tdata[31:0] != '0
      && m_tdata[63:60] == 4'b0000)
    else $error("accepted item has malformed ratio or rate");

endmodule

bind sample_rate_ratio_quantizer srrq_checker u_srrq_checker (.*);
